### src/hff_pkg.sv
`timescale 1ns / 1ps
package hff_pkg;

	// Sizes of the model
	localparam int MAX_STATES     = 4;
	localparam int EXP_TABLE_BITS = 10;
	localparam int STATE_W        = $clog2(MAX_STATES);
	localparam int CNT_W          = $clog2(MAX_STATES + 1);
	localparam int TRANS_DEPTH    = MAX_STATES * MAX_STATES;
	localparam int TRANS_W        = $clog2(TRANS_DEPTH);
	localparam int DIV_W          = 32 + STATE_W;
	localparam int COST_W         = EXP_TABLE_BITS + 17;
	localparam int FIDX_W         = $clog2(EXP_TABLE_BITS);
	localparam int DIV_CNT_W      = 6;

	// log2(e)/2 in Q0.32
	localparam logic [31:0] HALF_LOG2E_Q32 = 32'd3098164009;

	// Configuration register
	localparam int          PADDR_W          = 3;
	localparam logic        REG_IDX_NUM      = 1'b0;
	localparam logic [2:0]  NUM_STATES_RESET = 3'd4;

	// Request codes
	localparam logic [1:0] REQ_OBS     = 2'd0;
	localparam logic [1:0] REQ_WRITE   = 2'd1;
	localparam logic [1:0] REQ_RESTART = 2'd2;

	// Table codes
	localparam logic [1:0] TBL_INIT  = 2'd0;
	localparam logic [1:0] TBL_TRANS = 2'd1;
	localparam logic [1:0] TBL_MEAN  = 2'd2;
	localparam logic [1:0] TBL_VAR   = 2'd3;

	typedef enum logic [1:0] {
		CMD_OBS,
		CMD_WRITE,
		CMD_RESTART
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [1:0]         table_select;
		logic [3:0]         entry_index;
		logic [31:0]        model_value;
		logic signed [31:0] observation;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  state_index;
		logic [31:0] posterior;
		logic [1:0]  best_state;
		logic        used_uniform;
		logic        last;
	} result_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] hi;
		logic [31:0]      lo;
		logic [DIV_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quo;
	} div_rsp_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CLOAD,
		ST_CSQ,
		ST_CDIV,
		ST_CWAIT,
		ST_CQK,
		ST_CNORM,
		ST_CSQR,
		ST_CCOST,
		ST_PSTART,
		ST_PMUL,
		ST_PACC,
		ST_ESETUP,
		ST_EXP,
		ST_EAPPLY,
		ST_UMUL,
		ST_UACC,
		ST_DSTART,
		ST_DWAIT,
		ST_EMIT
	} eng_state_t;

	typedef logic [31:0] exp_fac_t [EXP_TABLE_BITS];

	// Integer square root, bit by bit
	function automatic logic [63:0] isqrt64(input logic [63:0] x);
		logic [63:0] r;
		logic [63:0] b;
		logic [63:0] rem;
		r   = '0;
		b   = 64'd1 << 62;
		rem = x;
		for (int k = 0; k < 32; k++) begin
			if (rem >= r + b) begin
				rem = rem - (r + b);
				r   = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Factors 2^(-2^-j) in Q0.32, j = 1 .. EXP_TABLE_BITS
	function automatic exp_fac_t exp_factors();
		exp_fac_t    f;
		logic [63:0] c;
		c = isqrt64(64'd1 << 63);
		for (int j = 0; j < EXP_TABLE_BITS; j++) begin
			f[j] = c[31:0];
			c    = isqrt64(c << 32);
		end
		return f;
	endfunction

	localparam exp_fac_t EXP_FAC = exp_factors();

endpackage

### src/hff_div.sv
`timescale 1ns / 1ps
// Restoring divider: quotient of {hi, lo} / den, 32 bits, saturated when hi >= den
module hff_div (
	input  logic               clk,
	input  logic               arst_n,
	input  hff_pkg::div_req_t  req,
	output hff_pkg::div_rsp_t  rsp
);

	logic                              busy_q;
	logic                              done_q;
	logic [hff_pkg::DIV_CNT_W-1:0]     cnt_q;
	logic [hff_pkg::DIV_W-1:0]         rem_q;
	logic [hff_pkg::DIV_W-1:0]         den_q;
	logic [31:0]                       lo_q;
	logic [31:0]                       quo_q;
	logic                              sat_q;
	logic [hff_pkg::DIV_W:0]           r2;
	logic                              ge;

	assign r2 = {rem_q, lo_q[31]};
	assign ge = r2 >= {1'b0, den_q};

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= hff_pkg::DIV_CNT_W'(32);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == hff_pkg::DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// One quotient bit per cycle
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.hi;
			lo_q  <= req.lo;
			den_q <= req.den;
			sat_q <= req.hi >= req.den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? hff_pkg::DIV_W'(r2 - {1'b0, den_q}) : r2[hff_pkg::DIV_W-1:0];
			lo_q  <= {lo_q[30:0], 1'b0};
			quo_q <= {quo_q[30:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = sat_q ? '1 : quo_q;

endmodule

### src/hff_front.sv
`timescale 1ns / 1ps
// Front: take items, sort them by kind, queue them for the engine
module hff_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [1:0]         req_type,
	input  logic [1:0]         table_select,
	input  logic [3:0]         entry_index,
	input  logic [31:0]        model_value,
	input  logic signed [31:0] observation,
	output logic               cmd_valid,
	output hff_pkg::cmd_t      cmd,
	input  logic               cmd_pop
);

	hff_pkg::cmd_t slot_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;
	logic          keep;
	logic          enq;
	logic          deq;
	hff_pkg::cmd_t cls;

	// Classify
	always_comb begin
		cls.table_select = table_select;
		cls.entry_index  = entry_index;
		cls.model_value  = model_value;
		cls.observation  = observation;
		keep             = 1'b1;
		cls.kind         = hff_pkg::CMD_OBS;
		unique case (req_type)
			hff_pkg::REQ_OBS:     cls.kind = hff_pkg::CMD_OBS;
			hff_pkg::REQ_WRITE:   cls.kind = hff_pkg::CMD_WRITE;
			hff_pkg::REQ_RESTART: cls.kind = hff_pkg::CMD_RESTART;
			default:              keep     = 1'b0;
		endcase
	end

	assign full      = count_q == 2'd2;
	assign enq       = push && !full && keep;
	assign deq       = cmd_pop && count_q != 2'd0;
	assign cmd_valid = count_q != 2'd0;
	assign cmd       = slot_q[rd_ptr_q];

	// Advance pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (enq) wr_ptr_q <= ~wr_ptr_q;
			if (deq) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, enq} - {1'b0, deq};
		end
	end

	// Hold payload
	always_ff @(posedge clk) begin
		if (enq) slot_q[wr_ptr_q] <= cls;
	end

endmodule

### src/hff_outq.sv
`timescale 1ns / 1ps
// Result queue between engine and output
module hff_outq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  hff_pkg::result_t    wr_data,
	output logic                q_full,
	output logic                q_empty,
	input  logic                rd_en,
	output hff_pkg::result_t    rd_data
);

	hff_pkg::result_t                 mem_q [hff_pkg::MAX_STATES];
	logic [hff_pkg::STATE_W-1:0]      wr_ptr_q;
	logic [hff_pkg::STATE_W-1:0]      rd_ptr_q;
	logic [hff_pkg::CNT_W-1:0]        count_q;
	logic                             do_wr;
	logic                             do_rd;

	assign q_full  = count_q == hff_pkg::CNT_W'(hff_pkg::MAX_STATES);
	assign q_empty = count_q == '0;
	assign do_wr   = wr_en && !q_full;
	assign do_rd   = rd_en && !q_empty;
	assign rd_data = mem_q[rd_ptr_q];

	// Advance pointers, wrapping at the depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (int'(wr_ptr_q) == hff_pkg::MAX_STATES - 1) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (int'(rd_ptr_q) == hff_pkg::MAX_STATES - 1) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + hff_pkg::CNT_W'(do_wr) - hff_pkg::CNT_W'(do_rd);
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wr_ptr_q] <= wr_data;
	end

endmodule

### src/hff_engine.sv
`timescale 1ns / 1ps
// Back end: table writes, restarts and the per-observation filter sequence
module hff_engine (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	input  hff_pkg::cmd_t       cmd,
	output logic                cmd_pop,
	input  logic [2:0]          num_states,
	input  logic                res_full,
	output logic                res_push,
	output hff_pkg::result_t    res
);

	localparam int F  = hff_pkg::EXP_TABLE_BITS;
	localparam int M  = hff_pkg::MAX_STATES;
	localparam int SW = hff_pkg::STATE_W;
	localparam int CW = hff_pkg::CNT_W;
	localparam int DW = hff_pkg::DIV_W;
	localparam int KW = hff_pkg::COST_W;

	hff_pkg::eng_state_t state_q, state_d;

	// Model tables
	logic [31:0]        init_q  [M];
	logic [31:0]        mean_q  [M];
	logic [31:0]        var_q   [M];
	logic [31:0]        trans_q [hff_pkg::TRANS_DEPTH];
	logic [31:0]        belief_q [M];
	logic               first_q;

	// Working registers
	logic [SW-1:0]      s_q;
	logic [SW-1:0]      i_q;
	logic signed [31:0] x_q;
	logic [30:0]        v_q;
	logic [31:0]        a_q;
	logic [63:0]        prod_q;
	logic [31:0]        q_q;
	logic [31:0]        m_q;
	logic [4:0]         p_q;
	logic [F-1:0]       frac_q;
	logic [hff_pkg::FIDX_W-1:0] k_q;
	logic [KW-1:0]      cost_q [M];
	logic [KW-1:0]      dmin_q;
	logic [DW-1:0]      acc_q;
	logic [31:0]        prior_q;
	logic [KW-1:0]      e_q;
	logic [F-1:0]       ef_q;
	logic [32:0]        ex_q;
	logic [31:0]        w_q;
	logic [31:0]        u_q [M];
	logic [DW-1:0]      sum_q;
	logic [SW-1:0]      best_q;
	logic [31:0]        best_val_q;

	// Combinational helpers
	logic [CW-1:0]      n_w;
	logic               s_last;
	logic               i_last;
	logic [SW-1:0]      rd_idx;
	logic [31:0]        bel_rd;
	logic [hff_pkg::TRANS_W-1:0] tr_addr;
	logic [32:0]        z_w;
	logic [32:0]        zabs_w;
	logic [31:0]        var_w;
	logic [30:0]        v_w;
	logic [63:0]        sq_w;
	logic [KW-1:0]      cost_w;
	logic [64:0]        exm_w;
	logic [KW-F-1:0]    nint_w;
	logic [32:0]        shf_w;
	logic [DW-1:0]      accn_w;
	logic [31:0]        uni_w [M+1];
	logic [31:0]        p_w;
	logic               upd;
	logic               sum_zero;
	hff_pkg::div_req_t  div_req;
	hff_pkg::div_rsp_t  div_rsp;

	hff_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Uniform fallback values, 2^32 / n
	for (genvar g = 0; g <= M; g++) begin : g_uni
		if (g < 2) begin : g_lo
			assign uni_w[g] = '0;
		end else begin : g_hi
			localparam logic [32:0] UNI = 33'h1_0000_0000 / 33'(g);
			assign uni_w[g] = UNI[31:0];
		end
	end

	// States in use, clamped
	always_comb begin
		if (int'(num_states) < 2) n_w = CW'(2);
		else if (int'(num_states) > M) n_w = CW'(M);
		else n_w = CW'(num_states);
	end

	assign s_last   = CW'(s_q) == n_w - CW'(1);
	assign i_last   = CW'(i_q) == n_w - CW'(1);
	assign rd_idx   = (state_q == hff_pkg::ST_PMUL) ? i_q : s_q;
	assign bel_rd   = belief_q[rd_idx];
	assign tr_addr  = hff_pkg::TRANS_W'(int'(i_q) * M + int'(s_q));
	assign sum_zero = sum_q == '0;

	// Distance to mean and floored variance
	assign var_w  = var_q[s_q];
	assign v_w    = (var_w[31] || var_w == '0) ? 31'd1 : var_w[30:0];
	assign z_w    = {x_q[31], x_q} - {mean_q[s_q][31], mean_q[s_q]};
	assign zabs_w = z_w[32] ? (~z_w + 33'd1) : z_w;

	assign sq_w   = m_q * m_q;
	assign cost_w = KW'(prod_q[63 -: (16 + F)]) + KW'({p_q, frac_q} >> 1);
	assign exm_w  = ex_q * hff_pkg::EXP_FAC[k_q];
	assign nint_w = e_q[KW-1:F];
	assign shf_w  = ex_q >> nint_w[4:0];
	assign accn_w = acc_q + DW'(prod_q[63:32]);

	assign p_w = sum_zero ? uni_w[n_w] : div_rsp.quo;
	assign upd = (state_q == hff_pkg::ST_DSTART && sum_zero)
		|| (state_q == hff_pkg::ST_DWAIT && div_rsp.done);

	// Divider requests: cost quotient, then posteriors
	always_comb begin
		div_req.start = 1'b0;
		div_req.hi    = DW'(prod_q[63:32]);
		div_req.lo    = prod_q[31:0];
		div_req.den   = DW'(v_q);
		if (state_q == hff_pkg::ST_CDIV) begin
			div_req.start = 1'b1;
		end else if (state_q == hff_pkg::ST_DSTART) begin
			div_req.start = !sum_zero;
			div_req.hi    = DW'(u_q[s_q]);
			div_req.lo    = '0;
			div_req.den   = sum_q;
		end
	end

	// Result
	assign res.state_index  = 2'(s_q);
	assign res.posterior    = bel_rd;
	assign res.best_state   = 2'(best_q);
	assign res.used_uniform = sum_zero;
	assign res.last         = s_last;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= hff_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	// Next state and handshake outputs
	always_comb begin
		state_d  = state_q;
		cmd_pop  = 1'b0;
		res_push = 1'b0;
		unique case (state_q)
			hff_pkg::ST_IDLE: begin
				cmd_pop = cmd_valid;
				if (cmd_valid && cmd.kind == hff_pkg::CMD_OBS) state_d = hff_pkg::ST_CLOAD;
			end
			hff_pkg::ST_CLOAD: state_d = hff_pkg::ST_CSQ;
			hff_pkg::ST_CSQ:   state_d = hff_pkg::ST_CDIV;
			hff_pkg::ST_CDIV:  state_d = hff_pkg::ST_CWAIT;
			hff_pkg::ST_CWAIT: if (div_rsp.done) state_d = hff_pkg::ST_CQK;
			hff_pkg::ST_CQK:   state_d = hff_pkg::ST_CNORM;
			hff_pkg::ST_CNORM: if (m_q[31]) state_d = hff_pkg::ST_CSQR;
			hff_pkg::ST_CSQR:  if (int'(k_q) == F - 1) state_d = hff_pkg::ST_CCOST;
			hff_pkg::ST_CCOST: state_d = s_last ? hff_pkg::ST_PSTART : hff_pkg::ST_CLOAD;
			hff_pkg::ST_PSTART: state_d = first_q ? hff_pkg::ST_ESETUP : hff_pkg::ST_PMUL;
			hff_pkg::ST_PMUL:  state_d = hff_pkg::ST_PACC;
			hff_pkg::ST_PACC:  state_d = i_last ? hff_pkg::ST_ESETUP : hff_pkg::ST_PMUL;
			hff_pkg::ST_ESETUP: state_d = hff_pkg::ST_EXP;
			hff_pkg::ST_EXP:   if (int'(k_q) == F - 1) state_d = hff_pkg::ST_EAPPLY;
			hff_pkg::ST_EAPPLY: state_d = hff_pkg::ST_UMUL;
			hff_pkg::ST_UMUL:  state_d = hff_pkg::ST_UACC;
			hff_pkg::ST_UACC:  state_d = s_last ? hff_pkg::ST_DSTART : hff_pkg::ST_PSTART;
			hff_pkg::ST_DSTART: begin
				if (!sum_zero) state_d = hff_pkg::ST_DWAIT;
				else if (s_last) state_d = hff_pkg::ST_EMIT;
			end
			hff_pkg::ST_DWAIT: begin
				if (div_rsp.done) state_d = s_last ? hff_pkg::ST_EMIT : hff_pkg::ST_DSTART;
			end
			hff_pkg::ST_EMIT: begin
				res_push = !res_full;
				if (!res_full && s_last) state_d = hff_pkg::ST_IDLE;
			end
			default: state_d = hff_pkg::ST_IDLE;
		endcase
	end

	// Control state: sequence flag, belief, winner
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
			for (int j = 0; j < M; j++) belief_q[j] <= '0;
			best_q     <= '0;
			best_val_q <= '0;
			s_q        <= '0;
			i_q        <= '0;
			k_q        <= '0;
		end else begin
			if (state_q == hff_pkg::ST_IDLE && cmd_valid) begin
				if (cmd.kind == hff_pkg::CMD_RESTART) first_q <= 1'b1;
				s_q <= '0;
			end
			if (state_q == hff_pkg::ST_CCOST || state_q == hff_pkg::ST_UACC) begin
				s_q <= s_last ? '0 : s_q + 1'b1;
			end
			if (state_q == hff_pkg::ST_PSTART) i_q <= '0;
			if (state_q == hff_pkg::ST_PACC) i_q <= i_q + 1'b1;
			if (state_q == hff_pkg::ST_CNORM || state_q == hff_pkg::ST_ESETUP) k_q <= '0;
			if (state_q == hff_pkg::ST_CSQR || state_q == hff_pkg::ST_EXP) k_q <= k_q + 1'b1;
			// Store posterior, track first maximum, drop unused states
			if (upd) begin
				belief_q[s_q] <= p_w;
				if (s_q == '0 || p_w > best_val_q) begin
					best_val_q <= p_w;
					best_q     <= s_q;
				end
				if (s_last) begin
					for (int j = 0; j < M; j++) begin
						if (j >= int'(n_w)) belief_q[j] <= '0;
					end
					first_q <= 1'b0;
					s_q     <= '0;
				end else begin
					s_q <= s_q + 1'b1;
				end
			end
			if (res_push) s_q <= s_q + 1'b1;
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			hff_pkg::ST_IDLE: begin
				sum_q <= '0;
				x_q   <= cmd.observation;
				if (cmd_valid && cmd.kind == hff_pkg::CMD_WRITE) begin
					unique case (cmd.table_select)
						hff_pkg::TBL_TRANS: begin
							if (int'(cmd.entry_index) < hff_pkg::TRANS_DEPTH)
								trans_q[cmd.entry_index[hff_pkg::TRANS_W-1:0]] <= cmd.model_value;
						end
						hff_pkg::TBL_INIT: begin
							if (int'(cmd.entry_index) < M)
								init_q[cmd.entry_index[SW-1:0]] <= cmd.model_value;
						end
						hff_pkg::TBL_MEAN: begin
							if (int'(cmd.entry_index) < M)
								mean_q[cmd.entry_index[SW-1:0]] <= cmd.model_value;
						end
						hff_pkg::TBL_VAR: begin
							if (int'(cmd.entry_index) < M)
								var_q[cmd.entry_index[SW-1:0]] <= cmd.model_value;
						end
					endcase
				end
			end
			hff_pkg::ST_CLOAD: begin
				v_q <= v_w;
				a_q <= zabs_w[31:0];
			end
			hff_pkg::ST_CSQ: prod_q <= a_q * a_q;
			hff_pkg::ST_CDIV: ;
			hff_pkg::ST_CWAIT: if (div_rsp.done) q_q <= div_rsp.quo;
			hff_pkg::ST_CQK: begin
				prod_q <= q_q * hff_pkg::HALF_LOG2E_Q32;
				m_q    <= {1'b0, v_q};
				p_q    <= 5'd31;
			end
			// Normalize: four places at a time, then single steps
			hff_pkg::ST_CNORM: begin
				frac_q <= '0;
				if (!m_q[31]) begin
					if (m_q[31:28] == 4'd0) begin
						m_q <= {m_q[27:0], 4'd0};
						p_q <= p_q - 5'd4;
					end else begin
						m_q <= {m_q[30:0], 1'b0};
						p_q <= p_q - 5'd1;
					end
				end
			end
			// One log fraction bit per squaring
			hff_pkg::ST_CSQR: begin
				m_q    <= sq_w[63] ? sq_w[63:32] : sq_w[62:31];
				frac_q <= {frac_q[F-2:0], sq_w[63]};
			end
			hff_pkg::ST_CCOST: begin
				cost_q[s_q] <= cost_w;
				if (s_q == '0 || cost_w < dmin_q) dmin_q <= cost_w;
			end
			hff_pkg::ST_PSTART: begin
				prior_q <= init_q[s_q];
				acc_q   <= '0;
			end
			hff_pkg::ST_PMUL: prod_q <= bel_rd * trans_q[tr_addr];
			hff_pkg::ST_PACC: begin
				acc_q <= accn_w;
				if (i_last) prior_q <= (accn_w[DW-1:32] != '0) ? '1 : accn_w[31:0];
			end
			hff_pkg::ST_ESETUP: begin
				e_q  <= cost_q[s_q] - dmin_q;
				ef_q <= cost_q[s_q][F-1:0] - dmin_q[F-1:0];
				ex_q <= 33'h1_0000_0000;
			end
			// Apply one root factor per fraction bit
			hff_pkg::ST_EXP: begin
				if (ef_q[F-1]) ex_q <= exm_w[64:32];
				ef_q <= {ef_q[F-2:0], 1'b0};
			end
			hff_pkg::ST_EAPPLY: begin
				if (int'(nint_w) >= 32) w_q <= '0;
				else w_q <= shf_w[32] ? '1 : shf_w[31:0];
			end
			hff_pkg::ST_UMUL: prod_q <= prior_q * w_q;
			hff_pkg::ST_UACC: begin
				u_q[s_q] <= prod_q[63:32];
				sum_q    <= sum_q + DW'(prod_q[63:32]);
			end
			hff_pkg::ST_DSTART: ;
			hff_pkg::ST_DWAIT: ;
			hff_pkg::ST_EMIT: ;
			default: ;
		endcase
	end

endmodule

### src/hmm_forward_filter_gaussian_top.sv
`timescale 1ns / 1ps
// Each observation uses the shared 32-step divider once per state for
// the cost quotient and once for the posterior, and the 10-step log and exp loops.
// The engine finishes one observation before it takes the next command;
// table writes and restarts are handled in the idle state.
// Reset: belief cleared, first-observation flag set, num_states = 4; tables undefined.
module hmm_forward_filter_gaussian_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [hff_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        push,
	output logic                        full,
	input  logic [1:0]                  req_type,
	input  logic [1:0]                  table_select,
	input  logic [3:0]                  entry_index,
	input  logic [31:0]                 model_value,
	input  logic signed [31:0]          observation,
	output logic                        empty,
	input  logic                        pop,
	output logic [1:0]                  state_index,
	output logic [31:0]                 posterior,
	output logic [1:0]                  best_state,
	output logic                        used_uniform,
	output logic                        last
);

	logic             [2:0] num_q;
	logic                   cmd_valid;
	hff_pkg::cmd_t          cmd;
	logic                   cmd_pop;
	logic                   res_full;
	logic                   res_push;
	hff_pkg::result_t       res;
	hff_pkg::result_t       head;
	logic                   sel_num;

	// Configuration register
	assign pready  = 1'b1;
	assign sel_num = paddr[2] == hff_pkg::REG_IDX_NUM;
	assign prdata  = sel_num ? {29'd0, num_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) num_q <= hff_pkg::NUM_STATES_RESET;
		else if (psel && penable && pwrite && pready && sel_num) num_q <= pwdata[2:0];
	end

	hff_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.req_type     (req_type),
		.table_select (table_select),
		.entry_index  (entry_index),
		.model_value  (model_value),
		.observation  (observation),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_pop      (cmd_pop)
	);

	hff_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.cmd_pop    (cmd_pop),
		.num_states (num_q),
		.res_full   (res_full),
		.res_push   (res_push),
		.res        (res)
	);

	hff_outq u_outq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res),
		.q_full  (res_full),
		.q_empty (empty),
		.rd_en   (pop),
		.rd_data (head)
	);

	assign state_index  = head.state_index;
	assign posterior    = head.posterior;
	assign best_state   = head.best_state;
	assign used_uniform = head.used_uniform;
	assign last         = head.last;

endmodule

### src/hff_checker.sv
`timescale 1ns / 1ps
module hff_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [1:0]  state_index,
	input logic [31:0] posterior,
	input logic [1:0]  best_state,
	input logic        used_uniform,
	input logic        last
);

	// Stalled result stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(posterior) && $stable(state_index)
			&& $stable(last) && $stable(used_uniform))
		else $error("stalled result changed");

	// Highest state always closes a run
	a_top_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && state_index == 2'(hff_pkg::MAX_STATES - 1) |-> last)
		else $error("top state not marked last");

	// Winner lies within the run
	a_best: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && last |-> best_state <= state_index)
		else $error("best state beyond run");

	// Results within a run count up
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && !last) ##1 !empty |-> state_index == $past(state_index) + 2'd1)
		else $error("state index out of order");

	// A new run starts at state zero
	a_first: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && last) ##1 !empty |-> state_index == 2'd0)
		else $error("run does not start at state zero");

endmodule

bind hmm_forward_filter_gaussian_top hff_checker u_hff_checker (.*);
